// File: src/ddw_pkg.sv
// Shared types, constants and table functions for the date day difference block.
package ddw_pkg;

    localparam int unsigned DAY_W     = 5;
    localparam int unsigned MONTH_W   = 4;
    localparam int unsigned YEAR_W    = 14;
    localparam int unsigned DAY_NUM_W = 23;
    localparam int unsigned DIST_W    = 22;
    localparam int unsigned WDAY_W    = 3;

    localparam logic [YEAR_W-1:0]  YEAR_MIN    = 14'd1600;
    localparam logic [MONTH_W-1:0] MONTH_JAN   = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC   = 4'd12;
    localparam logic [4:0]         FEB_LEAP    = 5'd29;
    localparam logic [17:0]        RECIP_25    = 18'd167773;
    localparam int unsigned        RECIP_SHIFT = 22;
    localparam logic [DIST_W-1:0]  DIST_MAX    = '1;

    typedef struct packed {
        logic                 valid;
        logic [DAY_NUM_W-1:0] day_num;
    } ddw_date_t;

    function automatic logic [4:0] month_len(input logic [MONTH_W-1:0] month);
        logic [4:0] len;
        unique case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] month_cum(input logic [MONTH_W-1:0] month);
        logic [8:0] cum;
        unique case (month)
            4'd1:    cum = 9'd0;
            4'd2:    cum = 9'd31;
            4'd3:    cum = 9'd59;
            4'd4:    cum = 9'd90;
            4'd5:    cum = 9'd120;
            4'd6:    cum = 9'd151;
            4'd7:    cum = 9'd181;
            4'd8:    cum = 9'd212;
            4'd9:    cum = 9'd243;
            4'd10:   cum = 9'd273;
            4'd11:   cum = 9'd304;
            4'd12:   cum = 9'd334;
            default: cum = 9'd0;
        endcase
        return cum;
    endfunction

    // Remainder by 7 through octal digit folding, since 8 is 1 modulo 7.
    function automatic logic [WDAY_W-1:0] mod7(input logic [DAY_NUM_W-1:0] value);
        logic [DAY_NUM_W+1:0] padded;
        logic [5:0]           digit_sum;
        logic [3:0]           fold;
        padded    = {2'b00, value};
        digit_sum = '0;
        for (int i = 0; i < (DAY_NUM_W + 2) / 3; i++)
        begin
            digit_sum = digit_sum + 6'(padded[3*i +: 3]);
        end
        fold = 4'(digit_sum[5:3]) + 4'(digit_sum[2:0]);
        if (fold >= 4'd7)
        begin
            fold = fold - 4'd7;
        end
        return fold[WDAY_W-1:0];
    endfunction

endpackage

// File: src/ddw_date_eval.sv
// Validity check and day number of one Gregorian date.
module ddw_date_eval
    import ddw_pkg::*;
(
    input  logic [DAY_W-1:0]   day,
    input  logic [MONTH_W-1:0] month,
    input  logic [YEAR_W-1:0]  year,
    output ddw_date_t          date
);

    logic [YEAR_W-1:0]    yr_prev;
    logic [YEAR_W-3:0]    quad;
    logic [29:0]          prod;
    logic [7:0]           cent_q;
    logic [YEAR_W-1:0]    cent_rem;
    logic                 cent_year;
    logic                 leap;
    logic [4:0]           lim;
    logic [DAY_NUM_W-1:0] yr_days;
    logic [DAY_NUM_W-1:0] mon_days;

    always_comb
    begin
        // The count of whole years before this one sets the year part.
        yr_prev   = year - 14'd1;
        quad      = yr_prev[YEAR_W-1:2];
        prod      = 30'(quad) * 30'(RECIP_25);
        cent_q    = prod[RECIP_SHIFT +: 8];
        cent_rem  = yr_prev - (14'(cent_q) * 14'd100);
        cent_year = (cent_rem == 14'd99);
        leap      = (year[1:0] == 2'b00) && (!cent_year || (cent_q[1:0] == 2'b11));

        lim = ((month == MONTH_FEB) && leap) ? FEB_LEAP : month_len(month);

        date.valid = (year >= YEAR_MIN) && (month >= MONTH_JAN) && (month <= MONTH_DEC)
                     && (day != '0) && (day <= lim);

        yr_days  = (23'(yr_prev) * 23'd365) + 23'(quad) - 23'(cent_q) + 23'(cent_q[7:2]);
        mon_days = 23'(month_cum(month)) + (((month > MONTH_FEB) && leap) ? 23'd1 : 23'd0);
        date.day_num = yr_days + mon_days + 23'(day);
    end

endmodule

// File: src/date_day_difference_weekday.sv
// Top level: day distance and weekday offset between two Gregorian dates.
//
//  Channel   Handshake         Payload
//  -------   ---------------   ------------------------------------------------
//  input     start, busy       first_day/month/year, second_day/month/year
//  result    done (strobe)     first_valid, second_valid, day_distance,
//                              weekday_offset
//
// A date pair is taken at every edge with start high; busy stays low.
// The result passes through the stages below and shows for one cycle, with done high.
// The first stage holds the two day numbers, the second the difference.
// Reset clears the stage valid flags, so no stale result is strobed.
// The receiver cannot stall, so nothing holds the pipeline.
module date_day_difference_weekday
    import ddw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [DAY_W-1:0]   first_day,
    input  logic [MONTH_W-1:0] first_month,
    input  logic [YEAR_W-1:0]  first_year,
    input  logic [DAY_W-1:0]   second_day,
    input  logic [MONTH_W-1:0] second_month,
    input  logic [YEAR_W-1:0]  second_year,
    output logic               done,
    output logic               first_valid,
    output logic               second_valid,
    output logic [DIST_W-1:0]  day_distance,
    output logic [WDAY_W-1:0]  weekday_offset
);

    logic                 accept;
    ddw_date_t            first_next;
    ddw_date_t            second_next;
    ddw_date_t            first_reg;
    ddw_date_t            second_reg;
    logic                 stage_vld_reg;
    logic                 done_reg;
    logic [DAY_NUM_W:0]   diff;
    logic [DAY_NUM_W:0]   diff_neg;
    logic [DAY_NUM_W-1:0] mag;
    logic [WDAY_W-1:0]    mag_rem;
    logic [DIST_W-1:0]    dist_next;
    logic [WDAY_W-1:0]    wday_next;
    logic [DIST_W-1:0]    dist_reg;
    logic [WDAY_W-1:0]    wday_reg;
    logic                 first_valid_reg;
    logic                 second_valid_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    ddw_date_eval u_first
    (
        .day   (first_day),
        .month (first_month),
        .year  (first_year),
        .date  (first_next)
    );

    ddw_date_eval u_second
    (
        .day   (second_day),
        .month (second_month),
        .year  (second_year),
        .date  (second_next)
    );

    always_comb
    begin
        diff     = {1'b0, second_reg.day_num} - {1'b0, first_reg.day_num};
        diff_neg = -diff;
        mag      = diff[DAY_NUM_W] ? diff_neg[DAY_NUM_W-1:0] : diff[DAY_NUM_W-1:0];
        mag_rem  = mod7(mag);
        if (first_reg.valid && second_reg.valid)
        begin
            dist_next = mag[DAY_NUM_W-1] ? DIST_MAX : mag[DIST_W-1:0];
            // A backward distance turns into the complementary weekday step.
            wday_next = (diff[DAY_NUM_W] && (mag_rem != '0)) ? (3'd7 - mag_rem) : mag_rem;
        end
        else
        begin
            dist_next = '0;
            wday_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_vld_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            stage_vld_reg <= accept;
            done_reg      <= stage_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            first_reg  <= first_next;
            second_reg <= second_next;
        end
        if (stage_vld_reg)
        begin
            first_valid_reg  <= first_reg.valid;
            second_valid_reg <= second_reg.valid;
            dist_reg         <= dist_next;
            wday_reg         <= wday_next;
        end
    end

    assign done           = done_reg;
    assign first_valid    = first_valid_reg;
    assign second_valid   = second_valid_reg;
    assign day_distance   = dist_reg;
    assign weekday_offset = wday_reg;

endmodule

// File: src/ddw_checker.sv
// Port-level assertions for the date day difference block, with its bind.
module ddw_checker
    import ddw_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic               first_valid,
    input logic               second_valid,
    input logic [DIST_W-1:0]  day_distance,
    input logic [WDAY_W-1:0]  weekday_offset
);

    // Every accepted item is answered with a done strobe.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("accepted item not answered after two cycles");

    // A result strobe always traces back to an accepted item.
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result strobed without an accepted item");

    // An invalid date zeroes the distance and the weekday offset.
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (!first_valid || !second_valid)) |->
            ((day_distance == '0) && (weekday_offset == '0)))
        else $error("invalid date gave a nonzero result");

    // The same day on both sides means no weekday step, and the offset stays below 7.
    a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((weekday_offset != 3'd7) &&
                  ((day_distance != '0) || (weekday_offset == '0))))
        else $error("weekday offset out of range or inconsistent with distance");

endmodule

bind date_day_difference_weekday ddw_checker u_ddw_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .done           (done),
    .first_valid    (first_valid),
    .second_valid   (second_valid),
    .day_distance   (day_distance),
    .weekday_offset (weekday_offset)
);
